@@ rtl/core/qbc_pkg.sv @@
package qbc_pkg;

   // Bracket stack sizing.
   localparam int BRACKET_DEPTH = 64;
   localparam int STK_CNT_W     = $clog2(BRACKET_DEPTH + 1);
   localparam int STK_ADDR_W    = $clog2(BRACKET_DEPTH);

   // Result queue sizing: one request can produce up to three results.
   localparam int MAX_RESULTS = 3;
   localparam int Q_DEPTH     = 8;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   // Character constants.
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CASE_OFFSET = CH_LOWER_A - CH_UPPER_A;

   typedef enum logic [2:0] {
      MODE_START,
      MODE_DQUOTE,
      MODE_SQUOTE,
      MODE_UPPER_ID,
      MODE_PLAIN_ID
   } qbc_mode_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_STRAY_CLOSE,
      ERR_MISMATCH,
      ERR_UNCLOSED,
      ERR_OVERFLOW
   } qbc_error_type;

   typedef enum logic [1:0] {
      BR_NONE,
      BR_ROUND,
      BR_SQUARE,
      BR_CURLY
   } qbc_bracket_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       is_status;
      logic [2:0] error_code;
      logic       out_last;
   } qbc_result_type;

   // Commands from the scanner to the bracket stack.
   typedef struct packed {
      logic            push;
      logic            pop;
      logic            clear;
      qbc_bracket_type code;
   } qbc_stack_ctrl_type;

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return is_upper(c) || ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
   endfunction

   function automatic logic is_ident(input logic [7:0] c);
      return is_letter(c) || ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) || (c == CH_UNDER);
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return is_upper(c) ? (c + CASE_OFFSET) : c;
   endfunction

   function automatic qbc_bracket_type open_code(input logic [7:0] c);
      qbc_bracket_type code;
      case (c)
         CH_LPAREN: code = BR_ROUND;
         CH_LBRACK: code = BR_SQUARE;
         CH_LBRACE: code = BR_CURLY;
         default:   code = BR_NONE;
      endcase
      return code;
   endfunction

   function automatic qbc_bracket_type close_code(input logic [7:0] c);
      qbc_bracket_type code;
      case (c)
         CH_RPAREN: code = BR_ROUND;
         CH_RBRACK: code = BR_SQUARE;
         CH_RBRACE: code = BR_CURLY;
         default:   code = BR_NONE;
      endcase
      return code;
   endfunction

   function automatic qbc_result_type byte_item(input logic [7:0] c);
      qbc_result_type r;
      r.out_char   = c;
      r.is_status  = 1'b0;
      r.error_code = ERR_NONE;
      r.out_last   = 1'b0;
      return r;
   endfunction

   function automatic qbc_result_type status_item(input qbc_error_type code);
      qbc_result_type r;
      r.out_char   = 8'h00;
      r.is_status  = 1'b1;
      r.error_code = code;
      r.out_last   = 1'b1;
      return r;
   endfunction

endpackage

@@ rtl/core/qbc_if.sv @@
// Request channel: one command byte per request.
interface qbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;

   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// Result channel: rewritten bytes and the final status.
interface qbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       is_status;
   logic [2:0] error_code;
   logic       out_last;

   modport source (output valid, output out_char, output is_status, output error_code,
                   output out_last, input ready);
   modport sink   (input valid, input out_char, input is_status, input error_code,
                   input out_last, output ready);
endinterface

@@ rtl/core/qbc_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module qbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ rtl/core/qbc_stack.sv @@
// Bracket stack. The top entry lives in a register so that a closing bracket
// can be checked in the cycle it arrives; the entries below it live in RAM.
// The RAM read address always follows the next count, so the entry below the
// top is ready as soon as the new count takes effect, even across back-to-back pops.
module qbc_stack
   import qbc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  qbc_stack_ctrl_type     ctrl,
   output qbc_bracket_type        top,
   output logic [STK_CNT_W-1:0]   count
);

   logic [STK_CNT_W-1:0]  count_ff, count_in;
   qbc_bracket_type       top_ff, top_in;
   logic                  bypass_ff, bypass_in;
   logic [1:0]            byp_data_ff;
   logic [1:0]            rd_data;
   logic [1:0]            below_top;
   logic                  wr_en;
   logic [STK_ADDR_W-1:0] wr_addr;
   logic [STK_ADDR_W-1:0] rd_addr;
   logic [STK_CNT_W-1:0]  rd_cnt;

   // The old top goes down into RAM on a push.
   assign wr_en   = ctrl.push && (count_ff != '0);
   assign wr_addr = STK_ADDR_W'(count_ff - STK_CNT_W'(1));

   // The entry below the top, taking a write of the same address into account.
   assign below_top = bypass_ff ? byp_data_ff : rd_data;

   // Next count and top.
   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (ctrl.push) begin
         count_in = count_ff + STK_CNT_W'(1);
         top_in   = ctrl.code;
      end else if (ctrl.pop) begin
         count_in = count_ff - STK_CNT_W'(1);
         top_in   = qbc_bracket_type'(below_top);
      end
      if (ctrl.clear) begin
         count_in = '0;
      end
   end

   // Read the slot that will sit below the top after this cycle.
   assign rd_cnt    = count_in - STK_CNT_W'(2);
   assign rd_addr   = rd_cnt[STK_ADDR_W-1:0];
   assign bypass_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         bypass_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         bypass_ff <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      byp_data_ff <= top_ff;
   end

   qbc_ram #(
      .WIDTH (2),
      .DEPTH (BRACKET_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (top_ff),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   assign top   = top_ff;
   assign count = count_ff;

endmodule

@@ rtl/core/query_bracket_check_and_case_fold.sv @@
// Channel   Port      Direction  Contents
// request   req_ch    in         in_char, in_last
// result    rsp_ch    out        out_char, is_status, error_code, out_last
//
// One request is taken every cycle while results drain at about one per
// request; the eight-entry result queue sets this, since a request is only
// processed when three free slots remain. A request passes through the request
// register and then the queue before its first result shows. Reset is
// synchronous and clears all control state at once; the bracket store needs no
// clearing pass. A stalled result side fills the queue and then holds the
// request register, which drops req_ch.ready.
module query_bracket_check_and_case_fold
   import qbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   qbc_req_if.sink       req_ch,
   qbc_rsp_if.source     rsp_ch
);

   // Request register.
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_last_ff;
   logic       consume;
   logic       take;

   // Scanner state.
   qbc_mode_type  mode_ff, mode_in;
   logic          dot_ff, dot_in;
   qbc_error_type error_ff, error_in;
   logic          at_start;

   // Bracket stack interface.
   qbc_stack_ctrl_type   stk_ctrl;
   qbc_bracket_type      stk_top;
   logic [STK_CNT_W-1:0] stk_count;
   logic [STK_CNT_W-1:0] count_after;
   qbc_bracket_type      oc;
   qbc_bracket_type      cc;
   qbc_error_type        final_code;

   // Results produced by this request.
   qbc_result_type res [MAX_RESULTS];
   logic [1:0]     nres;

   // Result queue.
   qbc_result_type       q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_CNT_W-1:0]   q_cnt_ff;
   logic                 q_pop;

   // A request is processed only when its results surely fit.
   assign consume       = in_valid_ff && (q_cnt_ff <= Q_CNT_W'(Q_DEPTH - MAX_RESULTS));
   assign req_ch.ready  = !in_valid_ff || consume;
   assign take          = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_char_ff <= req_ch.in_char;
         in_last_ff <= req_ch.in_last;
      end
   end

   assign oc = open_code(in_char_ff);
   assign cc = close_code(in_char_ff);

   // Classify the byte, drive the stack and collect the results.
   always_comb begin
      mode_in     = mode_ff;
      dot_in      = dot_ff;
      error_in    = error_ff;
      at_start    = 1'b0;
      stk_ctrl    = '0;
      count_after = stk_count;
      final_code  = ERR_NONE;
      nres        = '0;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         res[k] = '0;
      end
      if (consume) begin
         if (error_ff == ERR_NONE) begin
            // A held dot is released as a colon when a letter follows.
            if (dot_ff) begin
               res[nres] = byte_item(is_letter(in_char_ff) ? CH_COLON : CH_DOT);
               nres      = nres + 2'd1;
               dot_in    = 1'b0;
            end
            case (mode_ff)
               MODE_DQUOTE: begin
                  res[nres] = byte_item(in_char_ff);
                  nres      = nres + 2'd1;
                  if (in_char_ff == CH_DQUOTE) begin
                     mode_in = MODE_START;
                  end
               end
               MODE_SQUOTE: begin
                  res[nres] = byte_item(in_char_ff);
                  nres      = nres + 2'd1;
                  if (in_char_ff == CH_SQUOTE) begin
                     mode_in = MODE_START;
                  end
               end
               MODE_UPPER_ID: begin
                  if (is_ident(in_char_ff)) begin
                     res[nres] = byte_item(fold_case(in_char_ff));
                     nres      = nres + 2'd1;
                  end else begin
                     at_start = 1'b1;
                  end
               end
               MODE_PLAIN_ID: begin
                  if (is_ident(in_char_ff)) begin
                     res[nres] = byte_item(in_char_ff);
                     nres      = nres + 2'd1;
                  end else begin
                     at_start = 1'b1;
                  end
               end
               default: begin
                  at_start = 1'b1;
               end
            endcase

            // Start of a symbol, also for the byte that ends an identifier.
            if (at_start) begin
               if (in_char_ff == CH_DQUOTE) begin
                  mode_in   = MODE_DQUOTE;
                  res[nres] = byte_item(in_char_ff);
                  nres      = nres + 2'd1;
               end else if (in_char_ff == CH_SQUOTE) begin
                  mode_in   = MODE_SQUOTE;
                  res[nres] = byte_item(in_char_ff);
                  nres      = nres + 2'd1;
               end else if (is_letter(in_char_ff)) begin
                  mode_in   = is_upper(in_char_ff) ? MODE_UPPER_ID : MODE_PLAIN_ID;
                  res[nres] = byte_item(fold_case(in_char_ff));
                  nres      = nres + 2'd1;
               end else begin
                  mode_in = MODE_START;
                  if (oc != BR_NONE) begin
                     if (stk_count == STK_CNT_W'(BRACKET_DEPTH)) begin
                        error_in = ERR_OVERFLOW;
                     end else begin
                        stk_ctrl.push = 1'b1;
                        stk_ctrl.code = oc;
                        count_after   = stk_count + STK_CNT_W'(1);
                        res[nres]     = byte_item(in_char_ff);
                        nres          = nres + 2'd1;
                     end
                  end else if (cc != BR_NONE) begin
                     if (stk_count == '0) begin
                        error_in = ERR_STRAY_CLOSE;
                     end else begin
                        stk_ctrl.pop = 1'b1;
                        count_after  = stk_count - STK_CNT_W'(1);
                        if (stk_top != cc) begin
                           error_in = ERR_MISMATCH;
                        end else begin
                           res[nres] = byte_item(in_char_ff);
                           nres      = nres + 2'd1;
                        end
                     end
                  end else if (in_char_ff == CH_DOT) begin
                     dot_in = 1'b1;
                  end else begin
                     res[nres] = byte_item(in_char_ff);
                     nres      = nres + 2'd1;
                  end
               end
            end
         end

         // The last byte closes the command with a status and a fresh state.
         if (in_last_ff) begin
            final_code = error_in;
            if ((error_in == ERR_NONE) && dot_in) begin
               res[nres] = byte_item(CH_DOT);
               nres      = nres + 2'd1;
            end
            if ((error_in == ERR_NONE) && (count_after != '0)) begin
               final_code = ERR_UNCLOSED;
            end
            res[nres]      = status_item(final_code);
            nres           = nres + 2'd1;
            mode_in        = MODE_START;
            dot_in         = 1'b0;
            error_in       = ERR_NONE;
            stk_ctrl.clear = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_START;
         dot_ff   <= 1'b0;
         error_ff <= ERR_NONE;
      end else begin
         mode_ff  <= mode_in;
         dot_ff   <= dot_in;
         error_ff <= error_in;
      end
   end

   qbc_stack u_stack (
      .clock (clock),
      .reset (reset),
      .ctrl  (stk_ctrl),
      .top   (stk_top),
      .count (stk_count)
   );

   // Result queue: up to three writes and one read per cycle.
   assign q_pop = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(nres);
         rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(q_pop);
         q_cnt_ff  <= q_cnt_ff + Q_CNT_W'(nres) - Q_CNT_W'(q_pop);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (2'(k) < nres) begin
            q_ff[wr_ptr_ff + Q_PTR_W'(k)] <= res[k];
         end
      end
   end

   assign rsp_ch.valid      = (q_cnt_ff != '0);
   assign rsp_ch.out_char   = q_ff[rd_ptr_ff].out_char;
   assign rsp_ch.is_status  = q_ff[rd_ptr_ff].is_status;
   assign rsp_ch.error_code = q_ff[rd_ptr_ff].error_code;
   assign rsp_ch.out_last   = q_ff[rd_ptr_ff].out_last;

   // The queue never overfills.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("result queue count above its depth");

   // The last byte leaves the scanner and the stack in their reset state.
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (consume && in_last_ff) |=>
         (mode_ff == MODE_START) && !dot_ff && (error_ff == ERR_NONE) && (stk_count == '0))
      else $error("state not cleared after the last byte");

   // A recorded error holds until the command ends.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      ((error_ff != ERR_NONE) && !(consume && in_last_ff)) |=> (error_ff == $past(error_ff)))
      else $error("recorded error changed before the last byte");

   // After an error, bytes other than the last produce no results.
   a_error_swallows: assert property (@(posedge clock) disable iff (reset)
      ((error_ff != ERR_NONE) && consume && !in_last_ff) |-> (nres == '0))
      else $error("result produced after an error");

   // The stack never holds more than its depth.
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stk_count <= STK_CNT_W'(BRACKET_DEPTH))
      else $error("bracket stack count above its depth");

endmodule
